// File: hw/rtl/avr_pkg.sv
package avr_pkg;

  // Gain word: unsigned Q1.23
  localparam int unsigned GainBits  = 24;
  localparam int unsigned StepBits  = 25;
  localparam int unsigned CountBits = 4;
  localparam int unsigned IndexBits = 2;
  localparam int unsigned DataBits  = 25;

  // Ramp arithmetic runs on gain plus sign plus one headroom bit
  localparam int unsigned CalcBits = GainBits + 2;

  localparam logic [GainBits-1:0]         GainReset  = 24'h800000;
  localparam logic [CountBits-1:0]        CountReset = 4'd2;
  localparam logic [CountBits-1:0]        CountMin   = 4'd2;
  localparam logic signed [CalcBits-1:0]  RampEps    = 26'sd8;

  typedef enum logic [IndexBits-1:0] {
    RegStartVolume  = 2'd0,
    RegTargetVolume = 2'd1,
    RegRampStep     = 2'd2,
    RegChannelCount = 2'd3
  } avr_reg_e;

  // Occupancy of the scaling pipeline
  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
    logic s3_valid;
  } avr_pipe_t;

endpackage

// File: hw/rtl/avr_ctrl.sv
module avr_ctrl #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  avr_pkg::avr_reg_e              cfg_index_i,
  input  logic [avr_pkg::DataBits-1:0]   cfg_data_i,
  input  logic                           accept_i,
  output logic [avr_pkg::GainBits-1:0]   gain_o
);

  localparam int unsigned PosBits = (MAX_CHANNELS > 2) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [avr_pkg::CountBits-1:0] MaxCount = avr_pkg::CountBits'(MAX_CHANNELS);

  logic [avr_pkg::GainBits-1:0]  target_q;
  logic [avr_pkg::StepBits-1:0]  step_q;
  logic [avr_pkg::CountBits-1:0] count_q;
  logic [avr_pkg::GainBits-1:0]  gain_q, gain_d;
  logic                          fin_q, fin_d;
  logic [PosBits-1:0]            pos_q, pos_d;

  logic signed [avr_pkg::CalcBits-1:0] cur_s, tgt_s, step_s, sum_s, dist_up, dist_dn;
  logic [avr_pkg::CountBits-1:0]       frame_len;
  logic [avr_pkg::CountBits-1:0]       pos_inc;

  // Widen operands for the ramp step
  assign cur_s   = $signed({2'b00, gain_q});
  assign tgt_s   = $signed({2'b00, target_q});
  assign step_s  = $signed({step_q[avr_pkg::StepBits-1], step_q});
  assign sum_s   = cur_s + step_s;
  assign dist_up = tgt_s - cur_s;
  assign dist_dn = cur_s - tgt_s;

  // Advance the ramp at frame start, clamp at target
  always_comb begin
    gain_d = gain_q;
    fin_d  = fin_q;
    if (pos_q == '0 && !fin_q) begin
      if (!step_q[avr_pkg::StepBits-1]) begin
        if (dist_up > avr_pkg::RampEps) begin
          gain_d = (sum_s > tgt_s) ? target_q : sum_s[avr_pkg::GainBits-1:0];
        end else begin
          fin_d = 1'b1;
        end
      end else begin
        if (dist_dn > avr_pkg::RampEps) begin
          gain_d = (sum_s < tgt_s) ? target_q : sum_s[avr_pkg::GainBits-1:0];
        end else begin
          fin_d = 1'b1;
        end
      end
    end
  end

  assign gain_o = fin_d ? target_q : gain_d;

  // Clamp frame length to the supported channel range
  always_comb begin
    priority if (count_q < avr_pkg::CountMin) begin
      frame_len = avr_pkg::CountMin;
    end else if (count_q > MaxCount) begin
      frame_len = MaxCount;
    end else begin
      frame_len = count_q;
    end
  end

  assign pos_inc = avr_pkg::CountBits'(pos_q) + 4'd1;
  assign pos_d   = (pos_inc >= frame_len) ? '0 : pos_inc[PosBits-1:0];

  // Hold config and ramp state; a start_volume write reloads the gain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= avr_pkg::GainReset;
      step_q   <= '0;
      count_q  <= avr_pkg::CountReset;
      gain_q   <= avr_pkg::GainReset;
      fin_q    <= 1'b0;
      pos_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        avr_pkg::RegStartVolume: begin
          gain_q <= cfg_data_i[avr_pkg::GainBits-1:0];
          fin_q  <= 1'b0;
        end
        avr_pkg::RegTargetVolume: target_q <= cfg_data_i[avr_pkg::GainBits-1:0];
        avr_pkg::RegRampStep:     step_q   <= cfg_data_i[avr_pkg::StepBits-1:0];
        avr_pkg::RegChannelCount: count_q  <= cfg_data_i[avr_pkg::CountBits-1:0];
        default: ;
      endcase
    end else if (accept_i) begin
      gain_q <= gain_d;
      fin_q  <= fin_d;
      pos_q  <= pos_d;
    end
  end

endmodule

// File: hw/rtl/avr_scale.sv
module avr_scale #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  input  logic [avr_pkg::GainBits-1:0]  gain_i,
  output logic                          ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [SAMPLE_BITS-1:0]        sample_o,
  output logic [avr_pkg::GainBits-1:0]  gain_o,
  output avr_pkg::avr_pipe_t            pipe_o
);

  localparam int unsigned ProdBits = SAMPLE_BITS + avr_pkg::GainBits + 1;
  localparam int unsigned QBits    = ProdBits - 23;

  localparam logic signed [ProdBits-1:0] RoundBias =
    $signed({{(ProdBits-23){1'b0}}, 1'b1, 22'b0});
  localparam logic [SAMPLE_BITS-1:0] SatMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SatMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                          v1_q, v2_q, v3_q;
  logic                          adv1, adv2, adv3;
  logic [SAMPLE_BITS-1:0]        s1_sample_q;
  logic [avr_pkg::GainBits-1:0]  s1_gain_q, s2_gain_q, s3_gain_q;
  logic signed [ProdBits-1:0]    prod_d, prod_q, rnd;
  logic [QBits-1:0]              quo;
  logic [SAMPLE_BITS-1:0]        sat_d, s3_sample_q;

  // Move a stage when the one after it is free or moving
  assign adv3    = !v3_q || out_ready_i;
  assign adv2    = !v2_q || adv3;
  assign adv1    = !v1_q || adv2;
  assign ready_o = adv1;

  // Multiply sample by gain
  assign prod_d = $signed(s1_sample_q) * $signed({1'b0, s1_gain_q});

  // Round half up, drop fraction, saturate
  assign rnd = prod_q + RoundBias;
  assign quo = rnd[ProdBits-1:23];

  always_comb begin
    priority if (!quo[QBits-1] && quo[QBits-2:QBits-3] != 2'b00) begin
      sat_d = SatMax;
    end else if (quo[QBits-1] && quo[QBits-2:QBits-3] != 2'b11) begin
      sat_d = SatMin;
    end else begin
      sat_d = quo[SAMPLE_BITS-1:0];
    end
  end

  // Track stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= accept_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (adv1 && accept_i) begin
      s1_sample_q <= sample_i;
      s1_gain_q   <= gain_i;
    end
    if (adv2 && v1_q) begin
      prod_q    <= prod_d;
      s2_gain_q <= s1_gain_q;
    end
    if (adv3 && v2_q) begin
      s3_sample_q <= sat_d;
      s3_gain_q   <= s2_gain_q;
    end
  end

  assign out_valid_o     = v3_q;
  assign sample_o        = s3_sample_q;
  assign gain_o          = s3_gain_q;
  assign pipe_o.s1_valid = v1_q;
  assign pipe_o.s2_valid = v2_q;
  assign pipe_o.s3_valid = v3_q;

endmodule

// File: hw/rtl/audio_volume_ramp_top.sv
// Linear gain ramp fader for interleaved audio.
// Input channel (in_valid_i/in_ready_o): one signed sample per beat,
// channels interleaved; a frame is channel_count beats, clamped to 2..MAX_CHANNELS.
// Output channel (out_valid_o/out_ready_i): the scaled, rounded and
// saturated sample plus the gain that was applied to it.
// Config channel (cfg_valid_i/cfg_ready_o): register index and data;
// always ready. 0 start_volume (reloads the gain, restarts the ramp),
// 1 end gain of the ramp, 2 ramp_step (signed), 3 channel_count. Write only
// while no sample is in flight.
// Each beat passes the input, multiply and output registers in turn; one
// beat per cycle is sustained while out_ready_i stays high. The gain
// update for a frame is computed in the accept cycle, then multiply and
// round/saturate each take one register stage. Reset sets the gain and
// target to 1.0, step to 0, two channels, and empties the pipeline. When
// the receiver stalls, the three stages fill and in_ready_o drops only
// once the output register and both stages behind it hold beats.
module audio_volume_ramp_top #(
  parameter int unsigned SAMPLE_BITS  = 24,
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [SAMPLE_BITS-1:0]         sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [SAMPLE_BITS-1:0]         sample_out_o,
  output logic [avr_pkg::GainBits-1:0]   gain_used_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [avr_pkg::IndexBits-1:0]  cfg_index_i,
  input  logic [avr_pkg::DataBits-1:0]   cfg_data_i
);

  logic                          in_accept;
  logic                          cfg_we;
  logic [avr_pkg::GainBits-1:0]  item_gain;
  avr_pkg::avr_pipe_t            pipe;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_accept   = in_valid_i && in_ready_o;

  avr_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (avr_pkg::avr_reg_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (in_accept),
    .gain_o      (item_gain)
  );

  avr_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .sample_i    (sample_in_i),
    .gain_i      (item_gain),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_out_o),
    .gain_o      (gain_used_o),
    .pipe_o      (pipe)
  );

`ifndef ASSERT_OFF
  // Back pressure only comes from a stalled, full output
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && pipe.s1_valid && pipe.s2_valid)
    else $error("input stalled without a full pipeline");

  // A beat entering an empty pipeline passes through to out_valid_o unstalled
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !pipe.s1_valid && !pipe.s2_valid && !pipe.s3_valid |-> ##3 out_valid_o)
    else $error("beat lost in the pipeline");

  // The output register keeps its beat while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe.s3_valid && !out_ready_i |=> pipe.s3_valid)
    else $error("output beat dropped under stall");
`endif

endmodule

// File: sim/audio_volume_ramp_top_test.sv
`timescale 1ns / 100ps

module audio_volume_ramp_top_test;

  localparam int unsigned SampleBits  = 24;
  localparam int unsigned MaxChannels = 8;
  localparam int unsigned ItemTarget  = 1200;
  // Pipeline is three stages deep; leave some margin after the last beat
  localparam int unsigned DrainCycles = 8;
  // Cycles without a handshake on any channel before the run is declared hung
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned ReportLimit = 10;

  localparam longint SampleMax = (64'sd1 <<< (SampleBits - 1)) - 1;
  localparam longint SampleMin = -SampleMax - 1;
  localparam logic [avr_pkg::GainBits-1:0] GainFull = '1;

  typedef struct packed {
    logic [SampleBits-1:0]        sample;
    logic [avr_pkg::GainBits-1:0] gain;
  } scaled_beat_t;

  logic                          clk_i;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_ready_o;
  logic [SampleBits-1:0]         sample_in_i  = '0;
  logic                          out_valid_o;
  logic                          out_ready_i  = 1'b0;
  logic [SampleBits-1:0]         sample_out_o;
  logic [avr_pkg::GainBits-1:0]  gain_used_o;
  logic                          cfg_valid_i  = 1'b0;
  logic                          cfg_ready_o;
  logic [avr_pkg::IndexBits-1:0] cfg_index_i  = avr_pkg::RegStartVolume;
  logic [avr_pkg::DataBits-1:0]  cfg_data_i   = '0;

  // Shadow copy of the register file and the fader state
  logic [avr_pkg::GainBits-1:0]  cfg_start  = avr_pkg::GainReset;
  logic [avr_pkg::GainBits-1:0]  cfg_target = avr_pkg::GainReset;
  longint                        cfg_step   = 0;
  logic [avr_pkg::CountBits-1:0] cfg_count  = avr_pkg::CountReset;
  logic [avr_pkg::GainBits-1:0]  ramp_gain  = avr_pkg::GainReset;
  logic                          ramp_done  = 1'b0;
  int unsigned                   frame_pos  = 0;

  logic [SampleBits-1:0] sample_pending[$];
  scaled_beat_t          scaled_q[$];
  scaled_beat_t          want_beat;

  int unsigned errors        = 0;
  int unsigned idle_cycles   = 0;
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 73;
  int unsigned items_sent    = 0;
  bit          in_fire       = 1'b0;

  audio_volume_ramp_top #(
    .SAMPLE_BITS (SampleBits),
    .MAX_CHANNELS(MaxChannels)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_out_o(sample_out_o),
    .gain_used_o (gain_used_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Step the gain at frame start, scale the sample, queue the expected beat, advance the channel position
  task automatic apply_gain_ramp(input logic [SampleBits-1:0] raw);
    longint       s;
    longint       cur;
    longint       tgt;
    longint       nxt;
    longint       prod;
    int unsigned  flen;
    logic [avr_pkg::GainBits-1:0] gain;
    scaled_beat_t beat;
    s   = $signed(raw);
    cur = ramp_gain;
    tgt = cfg_target;
    if (frame_pos == 0 && !ramp_done) begin
      if (cfg_step >= 0) begin
        if (tgt - cur > longint'(avr_pkg::RampEps)) begin
          nxt = cur + cfg_step;
          if (nxt > tgt) nxt = tgt;
          ramp_gain = nxt[avr_pkg::GainBits-1:0];
        end else begin
          ramp_done = 1'b1;
        end
      end else begin
        if (cur - tgt > longint'(avr_pkg::RampEps)) begin
          nxt = cur + cfg_step;
          if (nxt < tgt) nxt = tgt;
          ramp_gain = nxt[avr_pkg::GainBits-1:0];
        end else begin
          ramp_done = 1'b1;
        end
      end
    end
    gain = ramp_done ? cfg_target : ramp_gain;

    // Round half up, floor by 2^23, saturate
    prod = s * longint'(gain) + (64'sd1 <<< 22);
    prod = prod >>> 23;
    if (prod > SampleMax) prod = SampleMax;
    if (prod < SampleMin) prod = SampleMin;
    beat.sample = prod[SampleBits-1:0];
    beat.gain   = gain;
    scaled_q.push_back(beat);

    // Advance the channel position, wrapping at the clamped frame length
    if (cfg_count < avr_pkg::CountMin) flen = avr_pkg::CountMin;
    else if (cfg_count > MaxChannels) flen = MaxChannels;
    else flen = cfg_count;
    if (frame_pos + 1 >= flen) frame_pos = 0;
    else frame_pos = frame_pos + 1;
  endtask

  // Write one register and mirror it in the shadow copy
  task automatic write_reg(input avr_pkg::avr_reg_e idx,
                           input logic [avr_pkg::DataBits-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      avr_pkg::RegStartVolume: begin
        cfg_start = data[avr_pkg::GainBits-1:0];
        ramp_gain = cfg_start;
        ramp_done = 1'b0;
      end
      avr_pkg::RegTargetVolume: cfg_target = data[avr_pkg::GainBits-1:0];
      avr_pkg::RegRampStep:     cfg_step = longint'($signed(data[avr_pkg::StepBits-1:0]));
      avr_pkg::RegChannelCount: cfg_count = data[avr_pkg::CountBits-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every queued sample went in and every result came out
  task automatic wait_idle();
    while (sample_pending.size() != 0 || in_valid_i || scaled_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [SampleBits-1:0] pick_sample();
    logic [31:0] rnd;
    rnd = $urandom();
    case ($urandom_range(7))
      0: return {1'b0, {(SampleBits - 1){1'b1}}};
      1: return {1'b1, {(SampleBits - 1){1'b0}}};
      2: return $urandom_range(1) ? '0 : '1;
      default: return rnd[SampleBits-1:0];
    endcase
  endfunction

  function automatic logic [avr_pkg::GainBits-1:0] pick_gain();
    logic [31:0] rnd;
    rnd = $urandom();
    case ($urandom_range(9))
      0: return '0;
      1: return GainFull;
      2: return avr_pkg::GainReset;
      default: return rnd[avr_pkg::GainBits-1:0];
    endcase
  endfunction

  // Drive the sample channel and the receiver's stalls on the falling edge
  always @(negedge clk_i) begin
    if (!(in_valid_i && !in_fire)) begin
      if (sample_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i  <= 1'b1;
        sample_in_i <= sample_pending[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Predict accepted input beats, check accepted output beats
  always @(posedge clk_i) begin
    in_fire = in_valid_i && in_ready_o;
    if (in_fire) begin
      apply_gain_ramp(sample_in_i);
      void'(sample_pending.pop_front());
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (scaled_q.size() == 0) begin
        errors++;
        if (errors <= ReportLimit)
          $display("unexpected output beat: sample_out %h gain_used %h",
                   sample_out_o, gain_used_o);
      end else begin
        want_beat = scaled_q.pop_front();
        if (sample_out_o !== want_beat.sample || gain_used_o !== want_beat.gain) begin
          errors++;
          if (errors <= ReportLimit)
            $display("mismatch: sample_out exp %h got %h, gain_used exp %h got %h",
                     want_beat.sample, sample_out_o, want_beat.gain, gain_used_o);
        end
      end
    end
  end

  // Watchdog: end the run when no channel moves a beat for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [avr_pkg::GainBits-1:0]  base_gain;
    logic [avr_pkg::GainBits-1:0]  tgt_gain;
    logic [avr_pkg::CountBits-1:0] count;
    logic [31:0]                   rnd;
    longint                        gap;
    longint                        mag;
    longint                        step;
    longint                        nudge;
    int unsigned                   n;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Reset settings: unity gain, zero step, ramp ends on the first frame
    sample_pending = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001};
    wait_idle();

    // Full-scale gain saturates both ways; count above range acts as eight
    write_reg(avr_pkg::RegStartVolume, {1'b1, GainFull});
    write_reg(avr_pkg::RegTargetVolume, {1'b0, GainFull});
    write_reg(avr_pkg::RegChannelCount, '1);
    sample_pending = '{24'h7FFFFF, 24'h800000, 24'h400000, 24'hC00000};
    wait_idle();

    // Ramp up in big steps and clamp at target; zero count acts as two
    write_reg(avr_pkg::RegStartVolume, '0);
    write_reg(avr_pkg::RegTargetVolume, 25'h0800000);
    write_reg(avr_pkg::RegRampStep, 25'h0300000);
    write_reg(avr_pkg::RegChannelCount, '0);
    repeat (6) sample_pending.push_back(pick_sample());
    wait_idle();

    // Steepest downward step clamps at target; odd frame length
    write_reg(avr_pkg::RegStartVolume, {1'b0, GainFull});
    write_reg(avr_pkg::RegTargetVolume, 25'h0100000);
    write_reg(avr_pkg::RegRampStep, 25'h1000000);
    write_reg(avr_pkg::RegChannelCount, 25'h0000003);
    repeat (4) sample_pending.push_back(pick_sample());
    wait_idle();

    // Stepping up from above target, reloaded mid-frame: the start gain holds until the frame ends
    write_reg(avr_pkg::RegStartVolume, 25'h0900000);
    write_reg(avr_pkg::RegRampStep, 25'h0001000);
    repeat (2) sample_pending.push_back(pick_sample());
    wait_idle();

    // Zero step holds the gain below target
    write_reg(avr_pkg::RegStartVolume, 25'h0000010);
    write_reg(avr_pkg::RegTargetVolume, {1'b0, GainFull});
    write_reg(avr_pkg::RegRampStep, '0);
    repeat (2) sample_pending.push_back(pick_sample());
    wait_idle();
    items_sent = 23;

    // Random phases, each with a fresh ramp setup and a random length
    while (items_sent < ItemTarget) begin
      if (items_sent < ItemTarget / 3) begin
        send_idle_pct = 17;
        recv_idle_pct = 73;
      end else if (items_sent < 2 * ItemTarget / 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // Mostly restart the ramp; otherwise carry the running state over
      if ($urandom_range(9) < 7) begin
        base_gain = pick_gain();
        write_reg(avr_pkg::RegStartVolume, {1'($urandom_range(1)), base_gain});
      end else begin
        base_gain = ramp_gain;
      end

      if ($urandom_range(3) == 0) begin
        nudge = longint'(base_gain) + longint'($urandom_range(32)) - 16;
        if (nudge < 0) nudge = 0;
        if (nudge > longint'(GainFull)) nudge = GainFull;
        tgt_gain = nudge[avr_pkg::GainBits-1:0];
      end else begin
        tgt_gain = pick_gain();
      end
      write_reg(avr_pkg::RegTargetVolume, {1'($urandom_range(1)), tgt_gain});

      // Half the time step toward target by at least a 40th of the gap; else zero, extremes, tiny or away
      gap = longint'(tgt_gain) - longint'(base_gain);
      mag = (gap < 0 ? -gap : gap) / longint'($urandom_range(40, 1));
      if (mag == 0) mag = 1;
      case ($urandom_range(9))
        0: step = 0;
        1: step = -(64'sd1 <<< 24);
        2: step = (64'sd1 <<< 24) - 1;
        3: begin
          step = longint'($urandom_range(16, 1));
          if ($urandom_range(1)) step = -step;
        end
        4: step = (gap < 0) ? mag : -mag;
        default: step = (gap < 0) ? -mag : mag;
      endcase
      write_reg(avr_pkg::RegRampStep, step[avr_pkg::StepBits-1:0]);

      if ($urandom_range(2) == 0) count = 4'($urandom_range(15));
      else count = 4'(2 * $urandom_range(4, 1));
      rnd = $urandom();
      write_reg(avr_pkg::RegChannelCount,
                {rnd[avr_pkg::DataBits-1:avr_pkg::CountBits], count});

      n = $urandom_range(150, 20);
      repeat (n) sample_pending.push_back(pick_sample());
      items_sent += n;
      wait_idle();
    end

    errors += scaled_q.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
